// ===== src/acad_pkg.sv =====
// Shared types and constants for the associative cache directory.
package acad_pkg;

  // Default number of directory entries.
  localparam int Entries = 16;

  // Field widths; the key and slot widths are fixed by the request and result formats.
  localparam int KeyW  = 64;
  localparam int SlotW = 4;
  localparam int PrioW = 14;

  // Priority given to a freshly written entry.
  localparam logic [PrioW-1:0] TopPriority = 14'd9999;

  // Request action codes.
  localparam logic ActLookup = 1'b0;
  localparam logic ActInsert = 1'b1;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             live;   // token is present at this stage
    logic             found;  // hit (lookup) or empty slot (insert) already seen
    logic [PrioW-1:0] best;   // lowest priority seen so far (insert)
  } tok_t;

endpackage

// ===== src/acad_cell.sv =====
// One directory entry: holds valid, key and priority, and advances the search token.
module acad_cell #(
  parameter int ENTRIES  = acad_pkg::Entries,
  parameter int KEY_BITS = acad_pkg::KeyW,
  parameter int IDX      = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  acad_pkg::tok_t             tok_in,
  input  logic [$clog2(ENTRIES)-1:0] slot_in,
  input  logic                       action,
  input  logic [KEY_BITS-1:0]        key,
  input  logic                       commit,
  input  logic [$clog2(ENTRIES)-1:0] victim,
  output acad_pkg::tok_t             tok_out,
  output logic [$clog2(ENTRIES)-1:0] slot_out
);
  import acad_pkg::*;

  localparam int IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  logic                valid;
  logic [KEY_BITS-1:0] entry_key;
  logic [PrioW-1:0]    prio;
  tok_t                tok_next;
  logic [IdxW-1:0]     slot_next;

  // Search step: first valid match for a lookup, first empty or lowest
  // priority slot for an insert.
  always_comb begin
    tok_next  = tok_in;
    slot_next = slot_in;
    if (tok_in.live && !tok_in.found) begin
      if (action == ActLookup) begin
        if (valid && entry_key == key) begin
          tok_next.found = 1'b1;
          slot_next      = MyIdx;
        end
      end else if (!valid) begin
        tok_next.found = 1'b1;
        slot_next      = MyIdx;
      end else if (prio < tok_in.best) begin
        tok_next.best = prio;
        slot_next     = MyIdx;
      end
    end
  end

  // Token stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= '0;
      slot_out <= '0;
    end else begin
      tok_out  <= tok_next;
      slot_out <= slot_next;
    end
  end

  // Entry update on an insert commit: the victim takes the key, the other
  // valid entries age by one, saturating at zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      prio  <= '0;
    end else if (commit) begin
      if (victim == MyIdx) begin
        valid <= 1'b1;
        prio  <= TopPriority;
      end else if (valid && prio != '0) begin
        prio <= prio - 1'b1;
      end
    end
  end

  // Key storage has no reset; it is only compared while valid.
  always_ff @(posedge clk) begin
    if (commit && victim == MyIdx) begin
      entry_key <= key;
    end
  end

endmodule

// ===== src/assoc_cache_directory_aging_replace.sv =====
// Fully associative cache directory with aging replacement, built as a chain of entry cells.
// A request is taken in the idle state; its search token then walks the chain one cell per
// cycle, the result is captured at the end of the chain, committed and loaded into the
// output register once that is free, and the block returns to idle for the next request.
// A new request is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) empties every entry and zeroes all priorities.
module assoc_cache_directory_aging_replace #(
  parameter int ENTRIES  = acad_pkg::Entries,
  parameter int KEY_BITS = acad_pkg::KeyW
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [71:0] s_tdata,   // [0] action, [64:1] key, [71:65] zero
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata     // [0] hit, [4:1] slot, [7:5] zero
);
  import acad_pkg::*;

  localparam int IdxW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state;
  logic                act;
  logic [KEY_BITS-1:0] key;
  tok_t                launch;
  tok_t                tok_chain  [ENTRIES+1];
  logic [IdxW-1:0]     slot_chain [ENTRIES+1];
  logic [ENTRIES-1:0]  live_vec;
  logic                res_found;
  logic [IdxW-1:0]     res_slot;
  logic                accept;
  logic                can_load;
  logic                commit;
  logic                hit;
  logic [SlotW-1:0]    slot;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign can_load = !m_tvalid || m_tready;
  assign commit   = (state == ST_DONE) && can_load && (act == ActInsert);

  assign tok_chain[0]  = launch;
  assign slot_chain[0] = '0;

  // Chain of entry cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    acad_cell #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_chain[i]),
      .slot_in  (slot_chain[i]),
      .action   (act),
      .key      (key),
      .commit   (commit),
      .victim   (res_slot),
      .tok_out  (tok_chain[i+1]),
      .slot_out (slot_chain[i+1])
    );
    assign live_vec[i] = tok_chain[i+1].live;
  end

  // Request capture; the key keeps only its low KEY_BITS bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      act <= s_tdata[0];
      key <= s_tdata[KEY_BITS:1];
    end
  end

  // Token launch into the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= '0;
    end else begin
      launch.live  <= accept;
      launch.found <= 1'b0;
      launch.best  <= TopPriority;
    end
  end

  // Sequencer: walk the chain, then commit and hand the result to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (tok_chain[ENTRIES].live) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result capture at the end of the chain.
  always_ff @(posedge clk) begin
    if (state == ST_WALK && tok_chain[ENTRIES].live) begin
      res_found <= tok_chain[ENTRIES].found;
      res_slot  <= slot_chain[ENTRIES];
    end
  end

  // Result formatting: inserts report no hit, a lookup miss reports slot zero.
  always_comb begin
    if (act == ActInsert) begin
      hit  = 1'b0;
      slot = SlotW'(res_slot);
    end else begin
      hit  = res_found;
      slot = res_found ? SlotW'(res_slot) : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && can_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && can_load) begin
      m_tdata <= {3'b000, slot, hit};
    end
  end

  // Only one search token is ever in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(live_vec) <= 1)
    else $error("more than one search token in the cell chain");

  // The token reaches the end of the chain only during a walk.
  a_end_in_walk: assert property (@(posedge clk) disable iff (rst)
    tok_chain[ENTRIES].live |-> state == ST_WALK)
    else $error("search token left the chain outside a walk");

  // An accepted request launches exactly one token into the chain.
  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> launch.live && state == ST_WALK)
    else $error("accepted request did not launch a search");

endmodule

// ===== tb/sv/directory_watch.sv =====
// Checker for the cache directory: tracks requests and replies, predicts and compares.
module directory_watch #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,   // [0] action, [64:1] key, [71:65] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [0] hit, [4:1] slot, [7:5] zero
  output int          errors,
  output int          pending,
  output int          hit_count,
  output int          miss_count,
  output int          insert_count,
  output int          evict_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import acad_pkg::*;

  // One reply as the block presents it.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } dir_reply_t;

  // Private copy of the directory contents.
  logic             dir_valid [ENTRIES];
  logic [KeyW-1:0]  dir_key   [ENTRIES];
  logic [PrioW-1:0] dir_prio  [ENTRIES];

  dir_reply_t expected_replies [$];

  initial begin
    errors       = 0;
    pending      = 0;
    hit_count    = 0;
    miss_count   = 0;
    insert_count = 0;
    evict_count  = 0;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    errors++;
  endtask

  // Apply one request to the private directory and work out the reply it causes.
  task automatic predict_directory_op(input logic act, input logic [KeyW-1:0] k,
                                      output dir_reply_t reply);
    int               victim;
    logic [PrioW-1:0] lowest;
    bit               have_empty;
    reply = '0;
    if (act == ActLookup) begin
      // Scan from the top so the lowest matching slot wins.
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (dir_valid[i] && dir_key[i] == k) begin
          reply.hit  = 1'b1;
          reply.slot = SlotW'(i);
        end
      end
      if (reply.hit) hit_count++;
      else miss_count++;
    end else begin
      // The first empty slot wins; otherwise the oldest entry below the top priority.
      victim     = 0;
      lowest     = TopPriority;
      have_empty = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!have_empty) begin
          if (!dir_valid[i]) begin
            have_empty = 1'b1;
            victim     = i;
          end else if (dir_prio[i] < lowest) begin
            lowest = dir_prio[i];
            victim = i;
          end
        end
      end
      insert_count++;
      if (!have_empty) evict_count++;
      dir_key[victim]   = k;
      dir_valid[victim] = 1'b1;
      dir_prio[victim]  = TopPriority;
      // Every other live entry ages by one, stopping at zero.
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != victim && dir_valid[i] && dir_prio[i] != '0) dir_prio[i] = dir_prio[i] - 1'b1;
      end
      reply.slot = SlotW'(victim);
    end
  endtask

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    dir_reply_t want;
    dir_reply_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        dir_valid[i] = 1'b0;
        dir_key[i]   = '0;
        dir_prio[i]  = '0;
      end
      expected_replies.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        predict_directory_op(s_tdata[0], s_tdata[KeyW:1], want);
        expected_replies.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.hit  = m_tdata[0];
        got.slot = m_tdata[SlotW:1];
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("reply hit=%0b slot=%0d with no request outstanding",
                                    got.hit, got.slot));
        end else begin
          want = expected_replies.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit: got %0b, expected %0b", got.hit, want.hit));
          if (got.slot !== want.slot)
            report_mismatch($sformatf("slot: got %0d, expected %0d", got.slot, want.slot));
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the cache directory testbench: clock, reset, request and reply traffic, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import acad_pkg::*;

  localparam int Entries      = 16;
  localparam int RandomReqs   = 1250;
  localparam int PoolSize     = 24;
  localparam int HoldCycles   = 400;
  localparam int DrainCycles  = Entries + 2 + 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [0] action, [64:1] key, [71:65] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] hit, [4:1] slot, [7:5] zero

  int errors;
  int pending;
  int hit_count;
  int miss_count;
  int insert_count;
  int evict_count;

  // Shared between the request and reply processes.
  bit steady;
  bit hold_req;

  logic [KeyW-1:0] key_pool [PoolSize];

  assoc_cache_directory_aging_replace #(
    .ENTRIES (Entries)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  directory_watch #(
    .ENTRIES (Entries)
  ) watch (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .errors       (errors),
    .pending      (pending),
    .hit_count    (hit_count),
    .miss_count   (miss_count),
    .insert_count (insert_count),
    .evict_count  (evict_count)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle gaps, now and then a long one; none during a steady stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Offer one request and hold it until accepted, then idle for a random gap.
  task automatic send_request(input logic act, input logic [KeyW-1:0] k);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, k, act};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Reply side: random backpressure, plus one long hold-off on request.
  initial begin
    int stall;
    stall    = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        stall = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Overall time limit.
  initial begin
    #10ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Request stream and verdict.
  initial begin
    logic            act;
    logic [KeyW-1:0] k;
    int              r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    steady   = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty directory, extreme keys, duplicate insert, fill and replacement.
    send_request(ActLookup, '0);
    send_request(ActLookup, '1);
    send_request(ActInsert, '0);
    send_request(ActInsert, '1);
    send_request(ActLookup, '0);
    send_request(ActLookup, '1);
    send_request(ActInsert, '1);
    send_request(ActLookup, '1);
    for (int i = 3; i < Entries; i++) send_request(ActInsert, rand_key());
    // Directory is full now: the oldest entry (key zero in slot 0) is replaced.
    send_request(ActInsert, rand_key());
    send_request(ActLookup, '0);

    // Random: mostly keys from a small pool so lookups hit and entries age out.
    for (int i = 0; i < PoolSize; i++) key_pool[i] = rand_key();
    for (int n = 0; n < RandomReqs; n++) begin
      steady = (n >= 300 && n < 450);
      if (n == 700) hold_req = 1'b1;
      if ($urandom_range(9) == 0) key_pool[$urandom_range(PoolSize - 1)] = rand_key();
      r   = $urandom_range(99);
      act = ($urandom_range(99) < 40) ? ActInsert : ActLookup;
      k   = (r < 85) ? key_pool[$urandom_range(PoolSize - 1)] : rand_key();
      send_request(act, k);
    end
    s_tvalid <= 1'b0;

    // Drain the remaining replies, then allow for anything stray.
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d lookups (%0d hits, %0d misses) and %0d inserts,",
             hit_count + miss_count, hit_count, miss_count, insert_count);
    $display("of which %0d replaced a live entry, with random gaps and one long reply stall.",
             evict_count);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
